// ===== src/shmm_pkg.sv =====
package shmm_pkg;

   // default number of cells the store is built for
   localparam int MAX_CELLS_DEF = 256;

   // field widths
   localparam int REQ_TYPE_W   = 2;
   localparam int SHIFT_W      = 10;
   localparam int INDEX_W      = 8;
   localparam int HEIGHT_IN_W  = 16;
   localparam int HEIGHT_W     = 15;
   localparam int CELL_W       = 16;
   localparam int CELLS_USED_W = 9;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_CELLS_USED = '0;

   // depth of the queue between front and back
   localparam int OPQ_DEPTH = 2;

   // height value that marks "none"
   localparam logic [HEIGHT_IN_W-1:0] NONE_HEIGHT = '1;

   // request codes
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_SHIFT = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   // operations handed from front to back
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_WRITE = 2'd2,
      OP_QUERY = 2'd3
   } op_kind_type;

endpackage

// ===== src/shmm_ram.sv =====
module shmm_ram #(
   parameter int WIDTH = shmm_pkg::CELL_W,
   parameter int DEPTH = shmm_pkg::MAX_CELLS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/shmm_front.sv =====
module shmm_front #(
   parameter int MAX_CELLS = shmm_pkg::MAX_CELLS_DEF,
   localparam int IDX_W = $clog2(MAX_CELLS),
   localparam int CNT_W = $clog2(MAX_CELLS + 1),
   localparam int OP_W  = 3 + IDX_W + CNT_W + shmm_pkg::HEIGHT_W
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  push,
   output logic                                  full,
   input  logic [shmm_pkg::REQ_TYPE_W-1:0]       req_type,
   input  logic signed [shmm_pkg::SHIFT_W-1:0]   req_shift_amount,
   input  logic [shmm_pkg::INDEX_W-1:0]          req_cell_index,
   input  logic signed [shmm_pkg::HEIGHT_IN_W-1:0] req_height,
   input  logic [shmm_pkg::INDEX_W-1:0]          req_first_cell,
   input  logic [shmm_pkg::INDEX_W-1:0]          req_last_cell,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [shmm_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [shmm_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [shmm_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready,
   // toward the back
   input  logic                                  q_full,
   input  logic                                  back_busy,
   output logic                                  q_push,
   output logic [OP_W-1:0]                       q_data,
   output logic                                  cfg_clear,
   output logic [CNT_W-1:0]                      cells_used
);

   localparam int CW = CNT_W + shmm_pkg::SHIFT_W;

   logic [CNT_W-1:0] cells_used_ff, cells_used_in;
   logic [IDX_W-1:0] ring_start_ff, ring_start_in;

   logic                        csr_wr, csr_hit;
   logic [CW-1:0]               csr_val;
   logic [CW-1:0]               n_ext, start_ext, mag_ext;
   logic [CW-1:0]               pos_sum, neg_sum, idx_sum, first_sum;
   logic [CW-1:0]               idx_ext, first_ext, last_ext;
   logic [shmm_pkg::SHIFT_W-1:0] sa, mag_raw;
   logic                        neg;

   shmm_pkg::op_kind_type       op_kind;
   logic                        op_status;
   logic [IDX_W-1:0]            op_base;
   logic [CNT_W-1:0]            op_count;
   logic [shmm_pkg::HEIGHT_W-1:0] op_height;
   logic [IDX_W-1:0]            ring_next;

   // register port decode
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_hit = (paddr[shmm_pkg::CSR_ADDR_W-1:2] == shmm_pkg::REG_CELLS_USED);
   assign cfg_clear = csr_wr & csr_hit;
   assign prdata  = csr_hit ? shmm_pkg::CSR_DATA_W'(cells_used_ff) : '0;
   assign cells_used = cells_used_ff;

   // clamp written cell count to one..MAX_CELLS
   always_comb begin
      csr_val = CW'(pwdata[shmm_pkg::CELLS_USED_W-1:0]);
      if (csr_val == '0) begin
         csr_val = CW'(1);
      end else if (csr_val > CW'(MAX_CELLS)) begin
         csr_val = CW'(MAX_CELLS);
      end
   end

   // shift magnitude, clamped to the cells in use
   always_comb begin
      n_ext     = CW'(cells_used_ff);
      start_ext = CW'(ring_start_ff);
      sa        = req_shift_amount;
      neg       = sa[shmm_pkg::SHIFT_W-1];
      mag_raw   = neg ? (~sa + shmm_pkg::SHIFT_W'(1)) : sa;
      mag_ext   = CW'(mag_raw);
      if (mag_ext > n_ext) begin
         mag_ext = n_ext;
      end
   end

   // ring positions, each wrapped once at the cell count
   always_comb begin
      idx_ext   = CW'(req_cell_index);
      first_ext = CW'(req_first_cell);
      last_ext  = CW'(req_last_cell);
      pos_sum   = start_ext + mag_ext;
      if (pos_sum >= n_ext) pos_sum = pos_sum - n_ext;
      neg_sum   = start_ext + n_ext - mag_ext;
      if (neg_sum >= n_ext) neg_sum = neg_sum - n_ext;
      idx_sum   = start_ext + idx_ext;
      if (idx_sum >= n_ext) idx_sum = idx_sum - n_ext;
      first_sum = start_ext + first_ext;
      if (first_sum >= n_ext) first_sum = first_sum - n_ext;
   end

   // classify the request into one back operation
   always_comb begin
      op_kind   = shmm_pkg::OP_NONE;
      op_status = 1'b0;
      op_base   = '0;
      op_count  = '0;
      op_height = req_height[shmm_pkg::HEIGHT_W-1:0];
      ring_next = ring_start_ff;
      case (shmm_pkg::req_kind_type'(req_type))
         shmm_pkg::REQ_CLEAR: begin
            op_kind  = shmm_pkg::OP_CLEAR;
            op_count = cells_used_ff;
         end
         shmm_pkg::REQ_SHIFT: begin
            if (mag_ext != '0) begin
               op_kind  = shmm_pkg::OP_CLEAR;
               op_count = mag_ext[CNT_W-1:0];
               if (neg) begin
                  op_base   = neg_sum[IDX_W-1:0];
                  ring_next = neg_sum[IDX_W-1:0];
               end else begin
                  op_base   = ring_start_ff;
                  ring_next = pos_sum[IDX_W-1:0];
               end
            end
         end
         shmm_pkg::REQ_WRITE: begin
            if (idx_ext >= n_ext) begin
               op_status = 1'b1;
            end else if (!req_height[shmm_pkg::HEIGHT_IN_W-1]) begin
               op_kind  = shmm_pkg::OP_WRITE;
               op_base  = idx_sum[IDX_W-1:0];
               op_count = CNT_W'(1);
            end
         end
         shmm_pkg::REQ_QUERY: begin
            if (first_ext > last_ext || last_ext >= n_ext) begin
               op_status = 1'b1;
            end else begin
               op_kind  = shmm_pkg::OP_QUERY;
               op_base  = first_sum[IDX_W-1:0];
               op_count = CNT_W'(last_ext - first_ext + CW'(1));
            end
         end
         default: begin
            op_kind = shmm_pkg::OP_NONE;
         end
      endcase
   end

   // accept while the queue has room and no clearing pass runs
   assign full   = q_full | back_busy;
   assign q_push = push & ~full;
   assign q_data = {op_kind, op_status, op_base, op_count, op_height};

   // next register values
   always_comb begin
      cells_used_in = cells_used_ff;
      ring_start_in = ring_start_ff;
      if (cfg_clear) begin
         cells_used_in = csr_val[CNT_W-1:0];
         ring_start_in = '0;
      end else if (q_push) begin
         ring_start_in = ring_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_used_ff <= CNT_W'(MAX_CELLS);
         ring_start_ff <= '0;
      end else begin
         cells_used_ff <= cells_used_in;
         ring_start_ff <= ring_start_in;
      end
   end

endmodule

// ===== src/shmm_opq.sv =====
module shmm_opq #(
   parameter int WIDTH = 1,
   parameter int DEPTH = shmm_pkg::OPQ_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/shmm_back.sv =====
module shmm_back #(
   parameter int MAX_CELLS = shmm_pkg::MAX_CELLS_DEF,
   localparam int IDX_W = $clog2(MAX_CELLS),
   localparam int CNT_W = $clog2(MAX_CELLS + 1),
   localparam int OP_W  = 3 + IDX_W + CNT_W + shmm_pkg::HEIGHT_W
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     cfg_clear,
   input  logic [CNT_W-1:0]                         cells_used,
   input  logic                                     q_empty,
   input  logic [OP_W-1:0]                          q_data,
   output logic                                     q_pop,
   output logic                                     busy,
   // result channel
   output logic                                     empty,
   input  logic                                     pop,
   output logic signed [shmm_pkg::HEIGHT_IN_W-1:0]  rsp_min_height,
   output logic signed [shmm_pkg::HEIGHT_IN_W-1:0]  rsp_max_height,
   output logic                                     rsp_status
);

   localparam int H = shmm_pkg::HEIGHT_W;
   localparam int CNT_LO  = H;
   localparam int BASE_LO = CNT_LO + CNT_W;
   localparam int ST_BIT  = BASE_LO + IDX_W;
   localparam int KIND_LO = ST_BIT + 1;

   typedef enum logic [1:0] {
      ST_SCRUB,
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic [CNT_W-1:0]          left_ff, left_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      out_valid_ff, out_valid_in;
   shmm_pkg::op_kind_type     kind_ff, kind_in;
   logic                      status_ff, status_in;
   logic [H-1:0]              height_ff, height_in;
   logic                      found_ff, found_in;
   logic [H-1:0]              lo_ff, lo_in, hi_ff, hi_in;
   logic [shmm_pkg::HEIGHT_IN_W-1:0] out_min_ff, out_min_in;
   logic [shmm_pkg::HEIGHT_IN_W-1:0] out_max_ff, out_max_in;
   logic                      out_status_ff, out_status_in;

   logic                      wr_en, rd_en, out_free;
   logic [shmm_pkg::CELL_W-1:0] wr_data, rd_data;
   logic [CNT_W-1:0]          addr_p1;
   logic [IDX_W-1:0]          addr_nx;
   logic [H-1:0]              rd_h;

   shmm_ram #(
      .WIDTH(shmm_pkg::CELL_W),
      .DEPTH(MAX_CELLS)
   ) u_cells (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign busy     = (state_ff == ST_SCRUB);
   assign empty    = ~out_valid_ff;
   assign out_free = ~out_valid_ff | pop;
   assign rsp_min_height = out_min_ff;
   assign rsp_max_height = out_max_ff;
   assign rsp_status     = out_status_ff;

   // walk the ring, wrapping at the cell count
   assign addr_p1 = CNT_W'(addr_ff) + CNT_W'(1);
   assign addr_nx = (addr_p1 >= cells_used) ? '0 : addr_p1[IDX_W-1:0];
   assign rd_h    = rd_data[H-1:0];

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      rd_valid_in   = 1'b0;
      out_valid_in  = out_valid_ff;
      kind_in       = kind_ff;
      status_in     = status_ff;
      height_in     = height_ff;
      found_in      = found_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      out_min_in    = out_min_ff;
      out_max_in    = out_max_ff;
      out_status_in = out_status_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      wr_data       = '0;
      q_pop         = 1'b0;

      // drop the result once it is transferred
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      // fold in the cell read last cycle
      if (rd_valid_ff && rd_data[shmm_pkg::CELL_W-1]) begin
         found_in = 1'b1;
         if (!found_ff || rd_h < lo_ff) lo_in = rd_h;
         if (!found_ff || rd_h > hi_ff) hi_in = rd_h;
      end

      case (state_ff)
         ST_SCRUB: begin
            if (left_ff != '0) begin
               wr_en   = 1'b1;
               addr_in = addr_nx;
               left_in = left_ff - CNT_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               kind_in   = shmm_pkg::op_kind_type'(q_data[KIND_LO +: 2]);
               status_in = q_data[ST_BIT];
               addr_in   = q_data[BASE_LO +: IDX_W];
               left_in   = q_data[CNT_LO +: CNT_W];
               height_in = q_data[0 +: H];
               found_in  = 1'b0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (left_ff != '0) begin
               if (kind_ff == shmm_pkg::OP_QUERY) begin
                  rd_en       = 1'b1;
                  rd_valid_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = (kind_ff == shmm_pkg::OP_WRITE) ? {1'b1, height_ff} : '0;
               end
               addr_in = addr_nx;
               left_in = left_ff - CNT_W'(1);
            end else if (!rd_valid_ff && out_free) begin
               // hand the result to the output register
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               if (kind_ff == shmm_pkg::OP_QUERY && found_ff) begin
                  out_min_in = {1'b0, lo_ff};
                  out_max_in = {1'b0, hi_ff};
               end else begin
                  out_min_in = shmm_pkg::NONE_HEIGHT;
                  out_max_in = shmm_pkg::NONE_HEIGHT;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new cell count restarts the clearing pass
      if (cfg_clear) begin
         state_in = ST_SCRUB;
         addr_in  = '0;
         left_in  = CNT_W'(MAX_CELLS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCRUB;
         addr_ff      <= '0;
         left_ff      <= CNT_W'(MAX_CELLS);
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         left_ff      <= left_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      height_ff     <= height_in;
      found_ff      <= found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      out_min_ff    <= out_min_in;
      out_max_ff    <= out_max_in;
      out_status_ff <= out_status_in;
   end

   // a read result only follows a cycle spent walking an operation
   a_read_from_run: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == ST_RUN))
      else $error("cell read data without a running operation");

   // the walk never leaves the cells in use
   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && left_ff != '0) |-> (CNT_W'(addr_ff) < cells_used))
      else $error("cell address beyond cell count");

   // the clearing pass produces no result
   a_scrub_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCRUB && !out_valid_ff) |=> !out_valid_ff)
      else $error("result produced during clearing pass");

endmodule

// ===== src/shifting_height_map_range_min_max.sv =====
// Shifting height map with range min/max. A row of cells (the count in use set
// by register 0, up to MAX_CELLS), each a known 15-bit height (7 fraction
// bits) or unknown, kept as a ring in one single-port cell memory. Requests
// are clear, shift, write and range query; each gives one result (min, max,
// status) on the result queue. A front stage checks and classifies requests
// and tracks the ring start; a two-entry queue feeds a back stage that walks
// the memory one cell per cycle. After reset and after each cell count write a
// clearing pass runs, during which full stays high; register writes are still
// taken.
module shifting_height_map_range_min_max #(
   parameter int MAX_CELLS = shmm_pkg::MAX_CELLS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request queue side
   input  logic                                    push,
   output logic                                    full,
   input  logic [shmm_pkg::REQ_TYPE_W-1:0]         req_type,
   input  logic signed [shmm_pkg::SHIFT_W-1:0]     req_shift_amount,
   input  logic [shmm_pkg::INDEX_W-1:0]            req_cell_index,
   input  logic signed [shmm_pkg::HEIGHT_IN_W-1:0] req_height,
   input  logic [shmm_pkg::INDEX_W-1:0]            req_first_cell,
   input  logic [shmm_pkg::INDEX_W-1:0]            req_last_cell,
   // result queue side
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [shmm_pkg::HEIGHT_IN_W-1:0] rsp_min_height,
   output logic signed [shmm_pkg::HEIGHT_IN_W-1:0] rsp_max_height,
   output logic                                    rsp_status,
   // register port
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [shmm_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [shmm_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [shmm_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   localparam int IDX_W = $clog2(MAX_CELLS);
   localparam int CNT_W = $clog2(MAX_CELLS + 1);
   localparam int OP_W  = 3 + IDX_W + CNT_W + shmm_pkg::HEIGHT_W;

   logic             q_full, q_empty, q_push, q_pop;
   logic [OP_W-1:0]  q_wdata, q_rdata;
   logic             back_busy, cfg_clear;
   logic [CNT_W-1:0] cells_used;

   // check and classify requests
   shmm_front #(.MAX_CELLS(MAX_CELLS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_shift_amount(req_shift_amount),
      .req_cell_index  (req_cell_index),
      .req_height      (req_height),
      .req_first_cell  (req_first_cell),
      .req_last_cell   (req_last_cell),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .q_full          (q_full),
      .back_busy       (back_busy),
      .q_push          (q_push),
      .q_data          (q_wdata),
      .cfg_clear       (cfg_clear),
      .cells_used      (cells_used)
   );

   // hold classified operations between the stages
   shmm_opq #(
      .WIDTH(OP_W),
      .DEPTH(shmm_pkg::OPQ_DEPTH)
   ) u_opq (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .empty    (q_empty)
   );

   // walk the cell memory and build results
   shmm_back #(.MAX_CELLS(MAX_CELLS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_clear     (cfg_clear),
      .cells_used    (cells_used),
      .q_empty       (q_empty),
      .q_data        (q_rdata),
      .q_pop         (q_pop),
      .busy          (back_busy),
      .empty         (empty),
      .pop           (pop),
      .rsp_min_height(rsp_min_height),
      .rsp_max_height(rsp_max_height),
      .rsp_status    (rsp_status)
   );

endmodule

// ===== sim/shmm_checker.sv =====
// Watch both queues and the register port, keep a copy of the height map,
// and compare every popped result with the answer owed for the oldest
// accepted request.
module shmm_checker
   import shmm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic [REQ_TYPE_W-1:0]         req_type,
   input  logic signed [SHIFT_W-1:0]     req_shift_amount,
   input  logic [INDEX_W-1:0]            req_cell_index,
   input  logic signed [HEIGHT_IN_W-1:0] req_height,
   input  logic [INDEX_W-1:0]            req_first_cell,
   input  logic [INDEX_W-1:0]            req_last_cell,
   input  logic                          empty,
   input  logic                          pop,
   input  logic signed [HEIGHT_IN_W-1:0] rsp_min_height,
   input  logic signed [HEIGHT_IN_W-1:0] rsp_max_height,
   input  logic                          rsp_status,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   input  logic [CSR_DATA_W-1:0]         prdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [HEIGHT_IN_W-1:0] min_h;
      logic signed [HEIGHT_IN_W-1:0] max_h;
      logic                          status;
   } answer_type;

   // bit 15 marks a known cell, bits 14..0 hold its height
   logic [CELL_W-1:0] cells [MAX_CELLS_DEF];
   int unsigned       ring_base;
   int unsigned       cell_count;
   answer_type        owed_answers [$];
   int                mismatches = 0;

   function automatic int unsigned phys(int unsigned logical);
      int unsigned p;
      p = ring_base + logical;
      if (p >= cell_count) p -= cell_count;
      return p;
   endfunction

   function automatic void wipe_cells();
      foreach (cells[i]) cells[i] = '0;
   endfunction

   // update the map for one request and return the answer it owes
   function automatic answer_type map_request(
      logic [REQ_TYPE_W-1:0] kind, logic [SHIFT_W-1:0] shift, logic [INDEX_W-1:0] idx,
      logic [HEIGHT_IN_W-1:0] h, logic [INDEX_W-1:0] first, logic [INDEX_W-1:0] last);
      answer_type  ans;
      int unsigned mag;
      int unsigned lo;
      int unsigned hi;
      bit          found;
      ans.min_h  = NONE_HEIGHT;
      ans.max_h  = NONE_HEIGHT;
      ans.status = 1'b0;
      lo         = 0;
      hi         = 0;
      found      = 1'b0;
      case (kind)
         REQ_CLEAR: begin
            wipe_cells();
         end
         REQ_SHIFT: begin
            mag = shift[SHIFT_W-1] ? (1 << SHIFT_W) - int'(shift) : int'(shift);
            if (mag > cell_count) mag = cell_count;
            if (mag != 0) begin
               if (!shift[SHIFT_W-1]) begin
                  // forward: drop front cells, back cells enter unknown
                  ring_base += mag;
                  if (ring_base >= cell_count) ring_base -= cell_count;
                  for (int unsigned i = cell_count - mag; i < cell_count; i++)
                     cells[phys(i)] = '0;
               end else begin
                  // backward: drop back cells, front cells enter unknown
                  ring_base += cell_count - mag;
                  if (ring_base >= cell_count) ring_base -= cell_count;
                  for (int unsigned i = 0; i < mag; i++)
                     cells[phys(i)] = '0;
               end
            end
         end
         REQ_WRITE: begin
            if (idx >= cell_count) ans.status = 1'b1;
            else if (!h[HEIGHT_IN_W-1]) cells[phys(idx)] = {1'b1, h[HEIGHT_W-1:0]};
         end
         default: begin
            if (first > last || last >= cell_count) begin
               ans.status = 1'b1;
            end else begin
               for (int unsigned i = first; i <= last; i++) begin
                  if (cells[phys(i)][CELL_W-1]) begin
                     if (!found || cells[phys(i)][HEIGHT_W-1:0] < lo)
                        lo = cells[phys(i)][HEIGHT_W-1:0];
                     if (!found || cells[phys(i)][HEIGHT_W-1:0] > hi)
                        hi = cells[phys(i)][HEIGHT_W-1:0];
                     found = 1'b1;
                  end
               end
               if (found) begin
                  ans.min_h = HEIGHT_IN_W'(lo);
                  ans.max_h = HEIGHT_IN_W'(hi);
               end
            end
         end
      endcase
      return ans;
   endfunction

   function automatic void note_mismatch(string what, longint expv, longint actv);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, expv, actv);
   endfunction

   always @(posedge clock) begin
      answer_type  got;
      answer_type  want;
      int unsigned n;
      if (reset) begin
         cell_count = MAX_CELLS_DEF;
         ring_base  = 0;
         wipe_cells();
         owed_answers.delete();
      end else begin
         // register access: a cell count write rebuilds the map
         if (psel && penable && pready && paddr[CSR_ADDR_W-1:2] == REG_CELLS_USED) begin
            if (pwrite) begin
               n = pwdata[CELLS_USED_W-1:0];
               if (n < 1) n = 1;
               if (n > MAX_CELLS_DEF) n = MAX_CELLS_DEF;
               cell_count = n;
               ring_base  = 0;
               wipe_cells();
            end else if (prdata != CSR_DATA_W'(cell_count)) begin
               note_mismatch("cell count readback", cell_count, prdata);
            end
         end
         // request transfer
         if (push && !full)
            owed_answers.insert(owed_answers.size(),
                                map_request(req_type, req_shift_amount, req_cell_index,
                                            req_height, req_first_cell, req_last_cell));
         // result transfer
         if (pop && !empty) begin
            got.min_h  = rsp_min_height;
            got.max_h  = rsp_max_height;
            got.status = rsp_status;
            if (owed_answers.size() == 0) begin
               note_mismatch("unexpected result, status", -1, got.status);
            end else begin
               want = owed_answers[0];
               owed_answers.delete(0);
               if (got.min_h != want.min_h) note_mismatch("min_height", want.min_h, got.min_h);
               if (got.max_h != want.max_h) note_mismatch("max_height", want.max_h, got.max_h);
               if (got.status != want.status) note_mismatch("status", want.status, got.status);
            end
         end
      end
      owed_count <= owed_answers.size();
      fail_count <= mismatches;
   end

endmodule

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import shmm_pkg::*;

   localparam int IDLE_LIMIT     = 5000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_PHASE = 78;
   localparam logic [CSR_ADDR_W-1:0] CELLS_USED_ADDR = {REG_CELLS_USED, 2'b00};
   // one word past the last register
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR      = CELLS_USED_ADDR + 3'd4;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic                          full;
   logic [REQ_TYPE_W-1:0]         req_type = REQ_CLEAR;
   logic signed [SHIFT_W-1:0]     req_shift_amount = '0;
   logic [INDEX_W-1:0]            req_cell_index = '0;
   logic signed [HEIGHT_IN_W-1:0] req_height = '0;
   logic [INDEX_W-1:0]            req_first_cell = '0;
   logic [INDEX_W-1:0]            req_last_cell = '0;
   logic                          empty;
   logic                          pop = 1'b0;
   logic signed [HEIGHT_IN_W-1:0] rsp_min_height;
   logic signed [HEIGHT_IN_W-1:0] rsp_max_height;
   logic                          rsp_status;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]         paddr = '0;
   logic [CSR_DATA_W-1:0]         pwdata = '0;
   logic [CSR_DATA_W-1:0]         prdata;
   logic                          pready;

   int          fail_count;
   int          owed_count;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   int unsigned cur_cells = MAX_CELLS_DEF;

   always #10 clock = ~clock;

   shifting_height_map_range_min_max i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_shift_amount (req_shift_amount),
      .req_cell_index   (req_cell_index),
      .req_height       (req_height),
      .req_first_cell   (req_first_cell),
      .req_last_cell    (req_last_cell),
      .empty            (empty),
      .pop              (pop),
      .rsp_min_height   (rsp_min_height),
      .rsp_max_height   (rsp_max_height),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   shmm_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_shift_amount (req_shift_amount),
      .req_cell_index   (req_cell_index),
      .req_height       (req_height),
      .req_first_cell   (req_first_cell),
      .req_last_cell    (req_last_cell),
      .empty            (empty),
      .pop              (pop),
      .rsp_min_height   (rsp_min_height),
      .rsp_max_height   (rsp_max_height),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .owed_count       (owed_count)
   );

   // result side: hold pop low now and then, never while calm
   always @(negedge clock) begin
      pop <= calm || ($urandom_range(0, 99) >= 7);
   end

   // end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** shifting_height_map_range_min_max: FAILED **");
            $finish;
         end
      end
   end

   // offer one request and hold it until the transfer
   task automatic send_request(req_kind_type kind, logic signed [SHIFT_W-1:0] shift,
                               logic [INDEX_W-1:0] idx, logic signed [HEIGHT_IN_W-1:0] h,
                               logic [INDEX_W-1:0] first, logic [INDEX_W-1:0] last);
      while (!calm && $urandom_range(0, 99) < 7) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push             <= 1'b1;
      req_type         <= kind;
      req_shift_amount <= shift;
      req_cell_index   <= idx;
      req_height       <= h;
      req_first_cell   <= first;
      req_last_cell    <= last;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // request whose unused fields carry random values
   task automatic send_op(req_kind_type kind, int shift, int idx, int h, int first,
                          int last);
      send_request(kind,
                   SHIFT_W'((kind == REQ_SHIFT) ? shift : $urandom_range(0, 512) - 256),
                   INDEX_W'((kind == REQ_WRITE) ? idx : $urandom_range(0, 255)),
                   HEIGHT_IN_W'((kind == REQ_WRITE) ? h : $urandom_range(0, 32768) - 1),
                   INDEX_W'((kind == REQ_QUERY) ? first : $urandom_range(0, 255)),
                   INDEX_W'((kind == REQ_QUERY) ? last : $urandom_range(0, 255)));
   endtask

   // setup and access cycle, then the port is left idle
   task automatic csr_access(bit is_write, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // stop offering requests and wait until every result is transferred
   task automatic wait_drained();
      push <= 1'b0;
      while (owed_count != 0) @(negedge clock);
   endtask

   // rebuild the map with a new cell count, then read it back
   task automatic set_cells(int unsigned value);
      wait_drained();
      csr_access(1'b1, CELLS_USED_ADDR, value);
      csr_access(1'b0, CELLS_USED_ADDR, '0);
      cur_cells = value % 512;
      if (cur_cells < 1) cur_cells = 1;
      if (cur_cells > MAX_CELLS_DEF) cur_cells = MAX_CELLS_DEF;
   endtask

   // mostly valid indices and ranges for the current cell count
   task automatic random_request(int unsigned n);
      int unsigned  pick;
      int unsigned  a;
      int unsigned  b;
      int           shift;
      int           h;
      int unsigned  idx;
      req_kind_type kind;
      pick = $urandom_range(0, 99);
      kind = (pick < 5) ? REQ_CLEAR : (pick < 25) ? REQ_SHIFT :
             (pick < 70) ? REQ_WRITE : REQ_QUERY;
      shift = $urandom_range(0, 512) - 256;
      if ($urandom_range(0, 3) != 0) shift = $urandom_range(0, 2 * n) - n;
      idx = $urandom_range(0, 255);
      if ($urandom_range(0, 9) != 0) idx = $urandom_range(0, n - 1);
      pick = $urandom_range(0, 99);
      h = (pick < 8) ? -1 : (pick < 12) ? 0 : (pick < 16) ? 32767 : $urandom_range(0, 32767);
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      if ($urandom_range(0, 99) < 85) begin
         a = $urandom_range(0, n - 1);
         b = $urandom_range(a, n - 1);
      end
      send_op(kind, shift, idx, h, a, b);
   endtask

   initial begin
      int unsigned phase_cells [PHASES];
      phase_cells = '{1, 256, 0, 2, 0, 511, 255, 0};
      phase_cells[4] = $urandom_range(3, 40);
      phase_cells[7] = $urandom_range(3, 40);
      phase_cells[2] = 0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset value of the register
      csr_access(1'b0, CELLS_USED_ADDR, '0);

      // full-size map: empty query, extreme heights, skipped write, reversed range
      send_op(REQ_QUERY, 0, 0, 0, 0, 255);
      send_op(REQ_WRITE, 0, 0, 0, 0, 0);
      send_op(REQ_WRITE, 0, 255, 32767, 0, 0);
      send_op(REQ_WRITE, 0, 5, -1, 0, 0);
      send_op(REQ_WRITE, 0, 10, 100, 0, 0);
      send_op(REQ_QUERY, 0, 0, 0, 0, 255);
      send_op(REQ_QUERY, 0, 0, 0, 3, 2);
      send_op(REQ_QUERY, 0, 0, 0, 5, 5);
      send_op(REQ_QUERY, 0, 0, 0, 10, 10);
      // one step each way, zero shift, then full shifts
      send_op(REQ_SHIFT, 1, 0, 0, 0, 0);
      send_op(REQ_QUERY, 0, 0, 0, 0, 255);
      send_op(REQ_SHIFT, -1, 0, 0, 0, 0);
      send_op(REQ_SHIFT, 0, 0, 0, 0, 0);
      send_op(REQ_QUERY, 0, 0, 0, 0, 255);
      send_op(REQ_SHIFT, 256, 0, 0, 0, 0);
      send_op(REQ_QUERY, 0, 0, 0, 0, 255);
      send_op(REQ_WRITE, 0, 128, 500, 0, 0);
      send_op(REQ_SHIFT, -256, 0, 0, 0, 0);
      send_op(REQ_QUERY, 0, 0, 0, 0, 255);
      send_op(REQ_WRITE, 0, 7, 7, 0, 0);
      send_op(REQ_CLEAR, 0, 0, 0, 0, 0);
      send_op(REQ_QUERY, 0, 0, 0, 0, 255);

      // a write past the register list leaves the map alone
      wait_drained();
      csr_access(1'b1, SPARE_ADDR, $urandom());
      csr_access(1'b0, CELLS_USED_ADDR, '0);

      // small map: index and range past the end, clamped shifts
      set_cells(4);
      send_op(REQ_WRITE, 0, 3, 9, 0, 0);
      send_op(REQ_WRITE, 0, 4, 9, 0, 0);
      send_op(REQ_QUERY, 0, 0, 0, 0, 4);
      send_op(REQ_QUERY, 0, 0, 0, 0, 3);
      send_op(REQ_SHIFT, 5, 0, 0, 0, 0);
      send_op(REQ_SHIFT, -200, 0, 0, 0, 0);

      // random phases over several cell counts
      for (int p = 0; p < PHASES; p++) begin
         set_cells(phase_cells[p]);
         calm = (p == 3);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) random_request(cur_cells);
         calm = 1'b0;
      end

      // drain, then let any stray result show up
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("** shifting_height_map_range_min_max: PASSED **");
      end else begin
         $display("** shifting_height_map_range_min_max: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/shmm_pkg.sv
src/shmm_ram.sv
src/shmm_front.sv
src/shmm_opq.sv
src/shmm_back.sv
src/shifting_height_map_range_min_max.sv
sim/shmm_checker.sv
sim/testbench.sv
